FILE: rtl/core/mts_pkg.sv
// Shared types and codes for the minimum-tracking stack.
// No dependencies; imported by the controller, datapath and top level.
package mts_pkg;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STS_OVERFLOW  = 2'd2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_WORD_W  = 32;
    localparam int DEPTH_OUT_W = 9;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       load;
        logic       capture;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

FILE: rtl/core/mts_ctrl.sv
// Controller state machine for the minimum-tracking stack.
// Depends on mts_pkg; drives the datapath through t_dp_cmd.
module mts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [1:0]        i_cmd,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  mts_pkg::t_dp_stat i_stat,
    output mts_pkg::t_dp_cmd  o_cmd
);
    import mts_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       r_rsp_valid, n_rsp_valid;
    logic       accept;

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = o_req_ready && i_req_valid;
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state  = ST_RESP;
                    n_status = STS_OK;
                    case (i_cmd)
                        CMD_PUSH: begin
                            if (i_stat.full) begin
                                n_status = STS_OVERFLOW;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (i_stat.empty) begin
                                n_status = STS_UNDERFLOW;
                            end else begin
                                o_cmd.pop = 1'b1;
                                n_state   = ST_LOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_RESP;
            end
            ST_RESP: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.capture = 1'b1;
                    n_rsp_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_status    <= STS_OK;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

FILE: rtl/core/mts_dpath.sv
// Datapath for the minimum-tracking stack: value and minimum stores,
// counts, top registers and the result register. Depends on mts_pkg.
module mts_dpath #(
    parameter int DEPTH       = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mts_pkg::t_dp_cmd                     i_cmd,
    output mts_pkg::t_dp_stat                    o_stat,
    input  logic signed [mts_pkg::OUT_WORD_W-1:0] i_push_value,
    output logic [1:0]                           o_status,
    output logic signed [mts_pkg::OUT_WORD_W-1:0] o_top_value,
    output logic signed [mts_pkg::OUT_WORD_W-1:0] o_min_value,
    output logic [mts_pkg::DEPTH_OUT_W-1:0]      o_depth_now,
    output logic                                 o_is_empty
);
    import mts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [VALUE_WIDTH-1:0] value_mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] min_mem   [DEPTH];

    logic [CW-1:0]                 r_vcount, r_mcount;
    logic signed [VALUE_WIDTH-1:0] r_vtop, r_mtop;
    logic signed [VALUE_WIDTH-1:0] r_vrd, r_mrd;
    logic                          r_min_popped;

    logic [1:0]                    r_status;
    logic signed [OUT_WORD_W-1:0]  r_top_out, r_min_out;
    logic [DEPTH_OUT_W-1:0]        r_depth_out;
    logic                          r_empty_out;

    logic signed [VALUE_WIDTH-1:0] push_val;
    logic                          min_push;
    logic                          min_pop;
    logic [AW-1:0]                 vrd_addr, mrd_addr;

    assign push_val = VALUE_WIDTH'(i_push_value);
    assign min_push = (r_mcount == '0) || (push_val <= r_mtop);
    assign min_pop  = (r_mcount != '0) && (r_vtop == r_mtop);
    assign vrd_addr = AW'(r_vcount - CW'(2));
    assign mrd_addr = AW'(r_mcount - CW'(2));

    assign o_stat.full  = (r_vcount == CW'(DEPTH));
    assign o_stat.empty = (r_vcount == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            value_mem[r_vcount[AW-1:0]] <= push_val;
            if (min_push) begin
                min_mem[r_mcount[AW-1:0]] <= push_val;
            end
        end
        r_vrd <= value_mem[vrd_addr];
        r_mrd <= min_mem[mrd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_mcount <= '0;
        end else if (i_cmd.push) begin
            r_vcount <= r_vcount + CW'(1);
            if (min_push) begin
                r_mcount <= r_mcount + CW'(1);
            end
        end else if (i_cmd.pop) begin
            r_vcount <= r_vcount - CW'(1);
            if (min_pop) begin
                r_mcount <= r_mcount - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_vtop <= push_val;
            if (min_push) begin
                r_mtop <= push_val;
            end
        end else if (i_cmd.pop) begin
            r_min_popped <= min_pop;
        end else if (i_cmd.load) begin
            r_vtop <= r_vrd;
            if (r_min_popped) begin
                r_mtop <= r_mrd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_status    <= i_cmd.status;
            r_top_out   <= (r_vcount != '0) ? OUT_WORD_W'(r_vtop) : '0;
            r_min_out   <= (r_vcount != '0) ? OUT_WORD_W'(r_mtop) : '0;
            r_depth_out <= DEPTH_OUT_W'(r_vcount);
            r_empty_out <= (r_vcount == '0);
        end
    end

    assign o_status    = r_status;
    assign o_top_value = r_top_out;
    assign o_min_value = r_min_out;
    assign o_depth_now = r_depth_out;
    assign o_is_empty  = r_empty_out;

endmodule

FILE: rtl/core/min_tracking_stack.sv
// Minimum-tracking stack: top level, stream ports over controller and datapath.
// A request moves from idle to the response state, where its result is registered; a pop
// that removes a value passes through a load state in between, which refills the top registers.
// No new request is taken until the last result is registered, and a held result output stalls that.
// Reset (synchronous, active low) clears counts and handshake state; the stores
// are not cleared and need no clearing pass.
module min_tracking_stack #(
    parameter int DEPTH       = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [1:0] cmd, [33:2] push_value, [39:34] zero
    input  logic [mts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] status, [33:2] top_value, [65:34] min_value, [74:66] depth_now,
    // [75] is_empty, [79:76] zero
    output logic [mts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import mts_pkg::*;

    t_dp_cmd                 dp_cmd;
    t_dp_stat                dp_stat;
    logic [1:0]              status;
    logic signed [OUT_WORD_W-1:0] top_value, min_value;
    logic [DEPTH_OUT_W-1:0]  depth_now;
    logic                    is_empty;

    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_cmd       (s_axis_tdata[1:0]),
        .o_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    mts_dpath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_push_value (s_axis_tdata[33:2]),
        .o_status     (status),
        .o_top_value  (top_value),
        .o_min_value  (min_value),
        .o_depth_now  (depth_now),
        .o_is_empty   (is_empty)
    );

    assign m_axis_tdata = {4'b0000, is_empty, depth_now, min_value, top_value, status};

endmodule

FILE: sim/tb_min_tracking_stack.sv
// Testbench for min_tracking_stack: drives stack requests over the stream slave
// port and checks every result against a behavioural stack with minimum tracking.
// Depends on mts_pkg for command and status codes and the stream data widths.
module tb_min_tracking_stack;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int         STACK_DEPTH    = 256;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] CMD_SPARE      = 2'd3;

    typedef struct packed {
        logic               is_empty;
        logic [8:0]         depth_now;
        logic signed [31:0] min_value;
        logic signed [31:0] top_value;
        logic [1:0]         status;
    } t_stack_view;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [1:0] cmd, [33:2] push_value, [39:34] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [1:0] status, [33:2] top_value, [65:34] min_value, [74:66] depth_now,
    // [75] is_empty, [79:76] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic signed [31:0] value_stack [STACK_DEPTH];
    logic signed [31:0] min_stack [STACK_DEPTH];
    int                 value_depth = 0;
    int                 min_depth = 0;
    t_stack_view        expected_views [$];
    t_stack_view        want_view;
    t_stack_view        got_view;
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    logic               no_gaps = 1'b0;

    min_tracking_stack dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_stack_view apply_stack_op(logic [1:0] op, logic signed [31:0] val);
        t_stack_view view;
        view.status = STS_OK;
        if (op == CMD_PUSH) begin
            if (value_depth >= STACK_DEPTH) begin
                view.status = STS_OVERFLOW;
            end else begin
                value_stack[value_depth] = val;
                value_depth++;
                if (min_depth == 0 || val <= min_stack[min_depth-1]) begin
                    min_stack[min_depth] = val;
                    min_depth++;
                end
            end
        end else if (op == CMD_POP) begin
            if (value_depth == 0) begin
                view.status = STS_UNDERFLOW;
            end else begin
                if (min_depth > 0 && value_stack[value_depth-1] == min_stack[min_depth-1])
                    min_depth--;
                value_depth--;
            end
        end
        view.top_value = (value_depth > 0) ? value_stack[value_depth-1] : '0;
        view.min_value = (value_depth > 0 && min_depth > 0) ? min_stack[min_depth-1] : '0;
        view.depth_now = 9'(value_depth);
        view.is_empty  = (value_depth == 0);
        return view;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:          return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2, 3, 4: return $urandom_range(0, 16) - 8;
            default:    return $urandom();
        endcase
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [31:0] val);
        while (!no_gaps && $urandom_range(0, 99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, val, op};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_views.insert(expected_views.size(), apply_stack_op(op, val));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_stack();
        send_request(CMD_QUERY, $urandom());
        send_request(CMD_POP, $urandom());
        send_request(CMD_SPARE, $urandom());
        send_request(CMD_POP, 32'hFFFF_FFFF);
        settle();
    endtask

    task automatic test_extremes();
        send_request(CMD_PUSH, 32'h7FFF_FFFF);
        send_request(CMD_PUSH, 32'h0000_0000);
        send_request(CMD_PUSH, 32'h8000_0000);
        send_request(CMD_PUSH, 32'h8000_0000);
        send_request(CMD_PUSH, 32'hFFFF_FFFF);
        send_request(CMD_QUERY, 32'h0);
        send_request(CMD_SPARE, 32'hFFFF_FFFF);
        repeat (5) send_request(CMD_POP, $urandom());
        send_request(CMD_POP, $urandom());
        settle();
    endtask

    task automatic test_full_stack();
        no_gaps = 1'b1;
        for (int i = 0; i < STACK_DEPTH; i++)
            send_request(CMD_PUSH, $urandom_range(0, 1) ? 32'(1000 - i) : pick_value());
        send_request(CMD_PUSH, $urandom());
        send_request(CMD_PUSH, 32'h8000_0000);
        send_request(CMD_QUERY, $urandom());
        repeat (STACK_DEPTH) send_request(CMD_POP, $urandom());
        send_request(CMD_POP, $urandom());
        settle();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_walk(input int count);
        int         sent;
        int         burst;
        int         push_share;
        int         roll;
        logic [1:0] op;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(10, 80);
            case ($urandom_range(0, 2))
                0:       push_share = 85;
                1:       push_share = 20;
                default: push_share = 50;
            endcase
            repeat (burst) begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    op = $urandom_range(0, 1) ? CMD_QUERY : CMD_SPARE;
                else if ($urandom_range(0, 99) < push_share)
                    op = CMD_PUSH;
                else
                    op = CMD_POP;
                send_request(op, pick_value());
                sent++;
            end
        end
        settle();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_view = m_axis_tdata[75:0];
            if (expected_views.size() == 0) begin
                $error("result with no request outstanding: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want_view = expected_views.pop_front();
                if (got_view.status !== want_view.status) begin
                    $error("status: expected %0d, got %0d", want_view.status, got_view.status);
                    mismatches++;
                end
                if (got_view.top_value !== want_view.top_value) begin
                    $error("top_value: expected %0d, got %0d",
                           want_view.top_value, got_view.top_value);
                    mismatches++;
                end
                if (got_view.min_value !== want_view.min_value) begin
                    $error("min_value: expected %0d, got %0d",
                           want_view.min_value, got_view.min_value);
                    mismatches++;
                end
                if (got_view.depth_now !== want_view.depth_now) begin
                    $error("depth_now: expected %0d, got %0d",
                           want_view.depth_now, got_view.depth_now);
                    mismatches++;
                end
                if (got_view.is_empty !== want_view.is_empty) begin
                    $error("is_empty: expected %0d, got %0d",
                           want_view.is_empty, got_view.is_empty);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_stack();
        test_extremes();
        test_full_stack();
        test_random_walk(1350);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
